// ----- hdl/fnem_pkg.sv -----
package fnem_pkg;

  localparam int MaxWidth = 512;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int FwW      = 10;
  localparam int FhW      = 12;
  localparam int PendW    = $clog2(MaxWidth + 1);
  localparam int CfgW     = 12;
  localparam int PixW     = 24;
  localparam int DiffW    = 10;
  localparam int SumW     = 12;

  localparam logic [FwW-1:0] FwReset = FwW'(512);
  localparam logic [FhW-1:0] FhReset = FhW'(256);

  typedef enum logic [0:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_reg_e;

  // one word headed for the difference stage
  typedef struct packed {
    logic            last;
    logic            sel;       // bank holding the centre row
    logic            en_pix;
    logic            en_vert;
    logic            en_left;
    logic            en_right;
    logic [PixW-1:0] pix;
  } item_t;

  function automatic logic [7:0] chan_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [DiffW-1:0] pix_diff(input logic [PixW-1:0] p,
                                                input logic [PixW-1:0] q);
    return DiffW'(chan_diff(p[7:0], q[7:0]))
         + DiffW'(chan_diff(p[15:8], q[15:8]))
         + DiffW'(chan_diff(p[23:16], q[23:16]));
  endfunction

endpackage

// ----- hdl/fnem_ram.sv -----
module fnem_ram #(
  parameter int Depth = 512,
  parameter int Width = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  // read-before-write on a shared address
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

endmodule

// ----- hdl/fnem_ctrl.sv -----
module fnem_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_index_i,
  input  logic [fnem_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                       fire_i,
  input  logic [7:0]                 red_i,
  input  logic [7:0]                 green_i,
  input  logic [7:0]                 blue_i,
  input  logic                       drain_i,
  output logic [1:0]                 mem_we_o,
  output logic [fnem_pkg::ColW-1:0]  mem_waddr_o,
  output logic [fnem_pkg::PixW-1:0]  mem_wdata_o,
  output logic [fnem_pkg::ColW-1:0]  raddr_a_o,
  output logic [fnem_pkg::ColW-1:0]  raddr_b_o,
  output logic                       item_valid_o,
  output fnem_pkg::item_t            item_o
);

  logic [fnem_pkg::FwW-1:0]   fw_q;
  logic [fnem_pkg::FhW-1:0]   fh_q;
  logic [fnem_pkg::ColW-1:0]  col_q, col_d;
  logic [fnem_pkg::FhW-1:0]   row_q, row_d;
  logic [fnem_pkg::PendW-1:0] pend_q, pend_d;

  logic [fnem_pkg::FwW-1:0]   eff_w;
  logic [fnem_pkg::FhW-1:0]   eff_h;
  logic [fnem_pkg::FwW-1:0]   col_p1;
  logic [fnem_pkg::FhW:0]     row_p1;
  logic                       pix_ok;
  logic                       drn_ok;
  logic [fnem_pkg::PixW-1:0]  pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= fnem_pkg::FwReset;
      fh_q <= fnem_pkg::FhReset;
    end else if (cfg_we_i) begin
      case (fnem_pkg::cfg_reg_e'(cfg_index_i))
        fnem_pkg::CfgFrameWidth:  fw_q <= cfg_data_i[fnem_pkg::FwW-1:0];
        fnem_pkg::CfgFrameHeight: fh_q <= cfg_data_i[fnem_pkg::FhW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_q == '0) begin
      eff_w = fnem_pkg::FwW'(1);
    end else if (fw_q > fnem_pkg::FwW'(fnem_pkg::MaxWidth)) begin
      eff_w = fnem_pkg::FwW'(fnem_pkg::MaxWidth);
    end else begin
      eff_w = fw_q;
    end
    eff_h = (fh_q == '0) ? fnem_pkg::FhW'(1) : fh_q;
  end

  assign col_p1 = fnem_pkg::FwW'(col_q) + fnem_pkg::FwW'(1);
  assign row_p1 = {1'b0, row_q} + (fnem_pkg::FhW + 1)'(1);
  assign pix    = {blue_i, green_i, red_i};
  assign pix_ok = fire_i && !drain_i && (pend_q == '0);
  assign drn_ok = fire_i && drain_i && (pend_q != '0);

  // line store write: current row's bank
  always_comb begin
    mem_we_o           = '0;
    mem_we_o[row_q[0]] = pix_ok;
  end
  assign mem_waddr_o = col_q;
  assign mem_wdata_o = pix;
  assign raddr_a_o   = col_q;
  assign raddr_b_o   = fnem_pkg::ColW'(col_p1);

  // pixel: centre is the row above; drain: centre is the final row itself
  always_comb begin
    item_o.last     = drain_i && (pend_q == fnem_pkg::PendW'(1));
    item_o.sel      = drain_i ? row_q[0] : ~row_q[0];
    item_o.en_pix   = !drain_i;
    item_o.en_vert  = drain_i ? (row_q != '0) : (row_q > fnem_pkg::FhW'(1));
    item_o.en_left  = (col_q != '0);
    item_o.en_right = (col_p1 < eff_w);
    item_o.pix      = pix;
    item_valid_o    = drn_ok || (pix_ok && (row_q != '0));
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    if (pix_ok) begin
      if (col_p1 >= eff_w) begin
        col_d = '0;
        if (row_p1 >= {1'b0, eff_h}) begin
          pend_d = fnem_pkg::PendW'(eff_w);
        end else begin
          row_d = row_p1[fnem_pkg::FhW-1:0];
        end
      end else begin
        col_d = fnem_pkg::ColW'(col_p1);
      end
    end else if (drn_ok) begin
      pend_d = pend_q - fnem_pkg::PendW'(1);
      col_d  = fnem_pkg::ColW'(col_p1);
      if (pend_q == fnem_pkg::PendW'(1)) begin
        row_d = '0;
        col_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
    end
  end

`ifndef SYNTHESIS
  a_no_write_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != '0) |-> (mem_we_o == '0))
    else $error("line store written while flushing");

  a_one_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(mem_we_o))
    else $error("both banks written");

  a_flush_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drn_ok && (pend_q == fnem_pkg::PendW'(1))) |=>
      ((pend_q == '0) && (row_q == '0) && (col_q == '0)))
    else $error("flush end did not rewind position");

  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= fnem_pkg::PendW'(fnem_pkg::MaxWidth))
    else $error("pending count out of range");
`endif

endmodule

// ----- hdl/fnem_datapath.sv -----
module fnem_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic                      item_valid_i,
  input  fnem_pkg::item_t           item_i,
  input  logic [fnem_pkg::PixW-1:0] m0_a_i,
  input  logic [fnem_pkg::PixW-1:0] m0_b_i,
  input  logic [fnem_pkg::PixW-1:0] m1_a_i,
  input  logic [fnem_pkg::PixW-1:0] m1_b_i,
  output logic                      ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                edge_value_o,
  output logic                      last_of_frame_o
);

  logic                       s1_valid_q;
  fnem_pkg::item_t            s1_item_q;
  logic                       s2_valid_q;
  logic                       s2_last_q;
  logic [fnem_pkg::DiffW-1:0] s2_d_q [4];
  logic [fnem_pkg::PixW-1:0]  left_q;

  logic                       out_free, s2_free, s1_free;
  logic [fnem_pkg::PixW-1:0]  centre, vert, right;
  logic [fnem_pkg::DiffW-1:0] d_pix, d_vert, d_left, d_right;
  logic [fnem_pkg::SumW-1:0]  sum;
  logic [fnem_pkg::SumW-3:0]  quarter;

  assign out_free = !out_valid_o || out_ready_i;
  assign s2_free  = !s2_valid_q || out_free;
  assign s1_free  = !s1_valid_q || s2_free;
  assign ready_o  = s1_free;

  always_comb begin
    centre  = s1_item_q.sel ? m1_a_i : m0_a_i;
    vert    = s1_item_q.sel ? m0_a_i : m1_a_i;
    right   = s1_item_q.sel ? m1_b_i : m0_b_i;
    d_pix   = s1_item_q.en_pix   ? fnem_pkg::pix_diff(s1_item_q.pix, centre) : '0;
    d_vert  = s1_item_q.en_vert  ? fnem_pkg::pix_diff(vert, centre)          : '0;
    d_left  = s1_item_q.en_left  ? fnem_pkg::pix_diff(left_q, centre)        : '0;
    d_right = s1_item_q.en_right ? fnem_pkg::pix_diff(right, centre)         : '0;
  end

  always_comb begin
    sum = fnem_pkg::SumW'(s2_d_q[0]) + fnem_pkg::SumW'(s2_d_q[1])
        + fnem_pkg::SumW'(s2_d_q[2]) + fnem_pkg::SumW'(s2_d_q[3]);
    quarter = sum[fnem_pkg::SumW-1:2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= fire_i && item_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_o <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && item_valid_i) begin
      s1_item_q <= item_i;
    end
    // left neighbour is the previous word's centre in the same row
    if (s1_valid_q && s2_free) begin
      left_q    <= centre;
      s2_d_q[0] <= d_pix;
      s2_d_q[1] <= d_vert;
      s2_d_q[2] <= d_left;
      s2_d_q[3] <= d_right;
      s2_last_q <= s1_item_q.last;
    end
    if (s2_valid_q && out_free) begin
      edge_value_o    <= (quarter > 10'd255) ? 8'd255 : quarter[7:0];
      last_of_frame_o <= s2_last_q;
    end
  end

endmodule

// ----- hdl/four_neighbour_edge_magnitude.sv -----
// Each word passes three registered stages in order (line store read, neighbor differences,
//   sum and saturate); a stalled output can hold a word in any of them.
// Throughput: one word per cycle; in_ready_o drops only while all three stages hold a word
//   and the output is stalled.
// Results for row r come with row r+1 pixels; drain words flush the final row.
// Reset clears position and pending count, sets width 512 and height 256; the line
//   store is not cleared and needs no clearing pass.
module four_neighbour_edge_magnitude (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_index_i,
  input  logic [fnem_pkg::CfgW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                red_i,
  input  logic [7:0]                green_i,
  input  logic [7:0]                blue_i,
  input  logic                      drain_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                edge_value_o,
  output logic                      last_of_frame_o
);

  logic                      fire;
  logic [1:0]                mem_we;
  logic [fnem_pkg::ColW-1:0] mem_waddr, raddr_a, raddr_b;
  logic [fnem_pkg::PixW-1:0] mem_wdata;
  logic [fnem_pkg::PixW-1:0] m0_a, m0_b, m1_a, m1_b;
  logic                      item_valid;
  fnem_pkg::item_t           item;

  assign fire = in_valid_i && in_ready_o;

  fnem_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fire_i       (fire),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .drain_i      (drain_i),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .raddr_a_o    (raddr_a),
    .raddr_b_o    (raddr_b),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  fnem_ram #(
    .Depth (fnem_pkg::MaxWidth),
    .Width (fnem_pkg::PixW)
  ) u_bank0 (
    .clk_i     (clk_i),
    .we_i      (mem_we[0]),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (fire),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (m0_a),
    .rdata_b_o (m0_b)
  );

  fnem_ram #(
    .Depth (fnem_pkg::MaxWidth),
    .Width (fnem_pkg::PixW)
  ) u_bank1 (
    .clk_i     (clk_i),
    .we_i      (mem_we[1]),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (fire),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (m1_a),
    .rdata_b_o (m1_b)
  );

  fnem_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .m0_a_i          (m0_a),
    .m0_b_i          (m0_b),
    .m1_a_i          (m1_a),
    .m1_b_i          (m1_b),
    .ready_o         (in_ready_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .edge_value_o    (edge_value_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule
